// ===== hw/rtl/rva2mg_pkg.sv =====
// shared types and constants for the relative-volume master gain parser
// no dependencies; imported by rva2mg_step and rva2_master_gain_parser_unit
package rva2mg_pkg;

    // which byte of a channel record comes next
    localparam logic [2:0] PH_TYPE    = 3'd0;
    localparam logic [2:0] PH_GAIN_HI = 3'd1;
    localparam logic [2:0] PH_GAIN_LO = 3'd2;
    localparam logic [2:0] PH_COUNT   = 3'd3;
    localparam logic [2:0] PH_PEAK    = 3'd4;

    // channel type code of the master volume record
    localparam logic [7:0] MASTER_TYPE = 8'h01;

    // largest number of peak bytes a record can carry
    localparam logic [5:0] MAX_PEAK_BYTES = 6'd32;

    // parser state carried between transactions
    typedef struct packed {
        logic [2:0]  phase;
        logic [5:0]  peak_left;
        logic [15:0] gain;
        logic        is_master;
        logic        answer_given;
    } parse_state_t;

    // result produced by one input byte
    typedef struct packed {
        logic        valid;
        logic        found;
        logic [15:0] gain;
    } parse_result_t;

endpackage

// ===== hw/rtl/rva2mg_step.sv =====
// next-state and result logic for one body byte of the parser
// depends on rva2mg_pkg for the state and result structs
module rva2mg_step (
    input  rva2mg_pkg::parse_state_t  cur_state,
    input  logic [7:0]                body_byte,
    input  logic                      end_of_body,
    output rva2mg_pkg::parse_state_t  next_state,
    output rva2mg_pkg::parse_result_t result
);
    import rva2mg_pkg::*;

    logic       complete;
    logic [8:0] peak_sum;
    logic [5:0] peak_count;
    logic [5:0] peak_dec;

    // peak byte count is ceil(bits/8)
    assign peak_sum   = {1'b0, body_byte} + 9'd7;
    assign peak_count = peak_sum[8:3];
    assign peak_dec   = (cur_state.peak_left != 6'd0) ? (cur_state.peak_left - 6'd1)
                                                      : cur_state.peak_left;

    always_comb begin
        next_state = cur_state;
        result     = '0;
        complete   = 1'b0;

        // record field decode, skipped once the answer is out
        if (!cur_state.answer_given) begin
            unique case (cur_state.phase)
                PH_GAIN_HI: begin
                    next_state.gain  = {body_byte, 8'h00};
                    next_state.phase = PH_GAIN_LO;
                end
                PH_GAIN_LO: begin
                    next_state.gain  = cur_state.gain | {8'h00, body_byte};
                    next_state.phase = PH_COUNT;
                end
                PH_COUNT: begin
                    if (peak_count == 6'd0) begin
                        complete = 1'b1;
                    end else begin
                        next_state.peak_left = peak_count;
                        next_state.phase     = PH_PEAK;
                    end
                end
                PH_PEAK: begin
                    next_state.peak_left = peak_dec;
                    if (peak_dec == 6'd0) begin
                        complete = 1'b1;
                    end
                end
                default: begin
                    // type byte, also taken for unused phase codes
                    next_state.is_master = (body_byte == MASTER_TYPE);
                    next_state.gain      = 16'h0000;
                    next_state.phase     = PH_GAIN_HI;
                end
            endcase

            // record finished: report a master record
            if (complete) begin
                next_state.phase     = PH_TYPE;
                next_state.peak_left = 6'd0;
                if (cur_state.is_master) begin
                    result.valid            = 1'b1;
                    result.found            = 1'b1;
                    result.gain             = next_state.gain;
                    next_state.answer_given = 1'b1;
                end
            end
        end

        // end of body: not-found answer if none given, then restart
        if (end_of_body) begin
            if (!next_state.answer_given) begin
                result.valid = 1'b1;
                result.found = 1'b0;
                result.gain  = 16'h0000;
            end
            next_state = '0;
        end
    end

endmodule

// ===== hw/rtl/rva2_master_gain_parser_unit.sv =====
// top level of the relative-volume master gain parser with stream ports
// depends on rva2mg_pkg and rva2mg_step
// a result is registered and shows on the master side in the cycle after the byte that causes it is accepted
// throughput: one body byte per cycle; the parser state updates in a single pass per byte
// the input side stalls only while a held result is not taken
// reset: aresetn low synchronously clears the parser state and the output valid
module rva2_master_gain_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] body_byte
    input  logic        s_tlast,   // end_of_body
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] gain (signed)
    output logic        m_tuser    // [0] found
);
    import rva2mg_pkg::*;

    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t step_result;
    logic          s_accept;
    logic          out_valid_reg;
    logic          out_found_reg;
    logic [15:0]   out_gain_reg;

    // accept while the output register is empty or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    rva2mg_step u_step (
        .cur_state   (state_reg),
        .body_byte   (s_tdata),
        .end_of_body (s_tlast),
        .next_state  (state_next),
        .result      (step_result)
    );

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_accept && step_result.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (s_accept && step_result.valid) begin
            out_found_reg <= step_result.found;
            out_gain_reg  <= step_result.gain;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_gain_reg;
    assign m_tuser  = out_found_reg;

    // a not-found result always carries zero gain
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 16'h0000))
        else $error("not-found result with nonzero gain");

    // once answered the parser sits at a record boundary
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.answer_given |-> (state_reg.phase == PH_TYPE && state_reg.peak_left == 6'd0))
        else $error("answered parser not at record boundary");

    // skipping peak bytes always has some left, and no more than MAX_PEAK_BYTES
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_PEAK) |->
            (state_reg.peak_left != 6'd0 && state_reg.peak_left <= MAX_PEAK_BYTES))
        else $error("peak byte count out of range");

    // a found result mid-body marks the answer as given
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && step_result.valid && step_result.found && !s_tlast)
            |=> state_reg.answer_given)
        else $error("found result without answer flag");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the relative-volume master gain parser unit
// depends on rva2mg_pkg and the rtl of rva2_master_gain_parser_unit
module tb;
    import rva2mg_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int MAX_GAP      = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 1900;
    localparam int DRAIN_CYCLES = 8;

    // one expected gain report
    typedef struct {
        logic        found;
        logic [15:0] gain;
    } gain_report_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] body_byte
    logic        s_tlast;   // end_of_body
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] gain (signed)
    logic        m_tuser;   // [0] found

    gain_report_t pending_reports[$];
    logic [7:0]   body_bytes[$];

    // shadow copy of the parser state
    logic [2:0]  sh_phase;
    logic [5:0]  sh_peak_left;
    logic [15:0] sh_gain;
    logic        sh_is_master;
    logic        sh_answered;

    int  mismatch_count;
    int  items_sent;
    int  quiet_cycles;
    int  stall_left;
    int  hold_left;
    int  hold_request;
    bit  idle_on;

    rva2_master_gain_parser_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // clear the shadow parser state
    task automatic clear_shadow();
        sh_phase     = PH_TYPE;
        sh_peak_left = '0;
        sh_gain      = '0;
        sh_is_master = 1'b0;
        sh_answered  = 1'b0;
    endtask

    // advance the shadow parser by one byte and queue any report it gives
    task automatic predict_gain_report(input logic [7:0] b, input logic is_last);
        logic         complete;
        logic [8:0]   peak;
        gain_report_t rep;
        complete = 1'b0;
        peak = ({1'b0, b} + 9'd7) >> 3;
        if (!sh_answered) begin
            case (sh_phase)
                PH_GAIN_HI: begin
                    sh_gain  = {b, 8'h00};
                    sh_phase = PH_GAIN_LO;
                end
                PH_GAIN_LO: begin
                    sh_gain  = sh_gain | {8'h00, b};
                    sh_phase = PH_COUNT;
                end
                PH_COUNT: begin
                    if (peak == 9'd0) begin
                        complete = 1'b1;
                    end else begin
                        sh_peak_left = peak[5:0];
                        sh_phase     = PH_PEAK;
                    end
                end
                PH_PEAK: begin
                    if (sh_peak_left != 6'd0) sh_peak_left = sh_peak_left - 6'd1;
                    if (sh_peak_left == 6'd0) complete = 1'b1;
                end
                default: begin
                    // type byte, also taken for any unused phase code
                    sh_is_master = (b == MASTER_TYPE);
                    sh_gain      = '0;
                    sh_phase     = PH_GAIN_HI;
                end
            endcase
            if (complete) begin
                sh_phase     = PH_TYPE;
                sh_peak_left = '0;
                if (sh_is_master) begin
                    rep.found = 1'b1;
                    rep.gain  = sh_gain;
                    pending_reports.push_back(rep);
                    sh_answered = 1'b1;
                end
            end
        end
        // end of body: report not-found if nothing was given, then restart
        if (is_last) begin
            if (!sh_answered) begin
                rep.found = 1'b0;
                rep.gain  = '0;
                pending_reports.push_back(rep);
            end
            clear_shadow();
        end
    endtask

    // offer one byte, entered and left at a falling edge
    task automatic send_body_byte(input logic [7:0] b, input logic is_last);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = is_last;
        do @(posedge aclk); while (!s_tready);
        predict_gain_report(b, is_last);
        items_sent++;
        @(negedge aclk);
    endtask

    // send the assembled body with the end flag on its final byte
    task automatic send_body();
        for (int i = 0; i < body_bytes.size(); i++)
            send_body_byte(body_bytes[i], i == body_bytes.size() - 1);
        body_bytes.delete();
    endtask

    // append one channel record with its peak bytes
    task automatic add_record(input logic [7:0] ch_type, input logic [15:0] gain,
                              input logic [7:0] peak_bits);
        int n_peak;
        n_peak = (int'(peak_bits) + 7) / 8;
        body_bytes.push_back(ch_type);
        body_bytes.push_back(gain[15:8]);
        body_bytes.push_back(gain[7:0]);
        body_bytes.push_back(peak_bits);
        repeat (n_peak) body_bytes.push_back(8'($urandom));
    endtask

    // master record whose zero peak count is also the final byte
    task automatic test_answer_on_final_byte();
        add_record(MASTER_TYPE, 16'h7fff, 8'd0);
        send_body();
    endtask

    // other record first, then a master record, then ignored trailing bytes
    task automatic test_master_after_other_record();
        add_record(8'h02, 16'h1234, 8'd9);
        add_record(MASTER_TYPE, 16'h8000, 8'd1);
        body_bytes.push_back(8'haa);
        body_bytes.push_back(8'h55);
        send_body();
    endtask

    // bodies that end inside a record or hold no master record
    task automatic test_cut_short_and_absent();
        body_bytes.push_back(MASTER_TYPE);
        body_bytes.push_back(8'h12);
        send_body();
        body_bytes.push_back(8'hff);
        send_body();
        add_record(8'h00, 16'hffff, 8'd0);
        send_body();
    endtask

    // receiver holds off while short master bodies keep arriving
    task automatic test_output_backpressure();
        idle_on      = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (6) begin
            add_record(MASTER_TYPE, 16'($urandom), 8'd0);
            send_body();
        end
    endtask

    // random bodies, mostly well-formed records with random content
    task automatic test_random_bodies();
        int kind;
        int n_rec;
        int keep;
        logic [7:0] ch_type;
        logic [7:0] peak_bits;
        while (items_sent < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // pure noise
                repeat ($urandom_range(1, 8)) body_bytes.push_back(8'($urandom));
            end else begin
                n_rec = $urandom_range(0, 4);
                repeat (n_rec) begin
                    ch_type = ($urandom_range(0, 2) == 0) ? MASTER_TYPE : 8'($urandom);
                    peak_bits = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                            : 8'($urandom_range(0, 24));
                    add_record(ch_type, 16'($urandom), peak_bits);
                end
                if (kind == 1 && body_bytes.size() > 1) begin
                    // cut the body short at a random byte
                    keep = $urandom_range(1, body_bytes.size() - 1);
                    while (body_bytes.size() > keep) void'(body_bytes.pop_back());
                end else if (kind < 5) begin
                    repeat ($urandom_range(1, 3)) body_bytes.push_back(8'($urandom));
                end
            end
            if (body_bytes.size() == 0) body_bytes.push_back(8'($urandom));
            send_body();
        end
    endtask

    // receiver: random stalls per result plus the long hold-off
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // compare each result transaction with the oldest expected report
    initial begin
        gain_report_t exp_rep;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                stall_left = idle_on ? $urandom_range(0, MAX_GAP) : 0;
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual found=%0b gain=%h",
                             $time, m_tuser, m_tdata);
                    mismatch_count++;
                end else begin
                    exp_rep = pending_reports.pop_front();
                    if (m_tuser !== exp_rep.found) begin
                        $display("%0t: found mismatch, expected %0b actual %0b",
                                 $time, exp_rep.found, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata !== exp_rep.gain) begin
                        $display("%0t: gain mismatch, expected %h actual %h",
                                 $time, exp_rep.gain, m_tdata);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // main sequence
    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        hold_request   = 0;
        idle_on        = 1'b1;
        mismatch_count = 0;
        items_sent     = 0;
        clear_shadow();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_answer_on_final_byte();
        test_master_after_other_record();
        test_cut_short_and_absent();
        test_output_backpressure();
        test_random_bodies();

        s_tvalid = 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/rva2mg_pkg.sv
hw/rtl/rva2mg_step.sv
hw/rtl/rva2_master_gain_parser_unit.sv
tb/tb.sv
